// ----- rtl/sme_pkg.sv -----
package sme_pkg;

   // Field widths fixed by the interface
   localparam int FILE_W = 6;
   localparam int CNT_W  = 7;
   localparam int OP_W   = 2;

   localparam logic [CNT_W-1:0] FILE_COUNT_RESET = 7'd64;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_LIST  = 2'd1;
   localparam logic [OP_W-1:0] OP_COUNT = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [FILE_W-1:0] file_sel;
      logic              group_last;
   } req_payload_type;

   typedef struct packed {
      logic [FILE_W-1:0] similar_file;
      logic              last_of_run;
      logic              none_found;
      logic [FILE_W-1:0] duplicate_count;
      logic              has_duplicates;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPLY_RD,
      ST_APPLY_WR,
      ST_FETCH,
      ST_LIST,
      ST_COUNT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic take;
      logic apply_read;
      logic apply_skip;
      logic apply_write;
      logic apply_end;
      logic fetch;
      logic list_emit;
      logic count_step;
      logic count_emit;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic apply_done;
      logic apply_member;
      logic is_count;
      logic work_zero;
      logic rest_zero;
      logic out_free;
   } dp_sts_type;

endpackage

// ----- rtl/sme_ctrl.sv -----
module sme_ctrl
   import sme_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  req_payload_type req_data,
   input  dp_sts_type      sts,
   output logic            req_ready,
   output dp_cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.operation) inside
                  OP_ADD: begin
                     if (req_data.group_last) state_in = ST_APPLY_RD;
                  end
                  OP_LIST, OP_COUNT: state_in = ST_FETCH;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_APPLY_RD: begin
            if (sts.apply_done) begin
               state_in = ST_IDLE;
            end else if (sts.apply_member) begin
               state_in = ST_APPLY_WR;
            end
         end
         ST_APPLY_WR: state_in = ST_APPLY_RD;
         ST_FETCH:    state_in = sts.is_count ? ST_COUNT : ST_LIST;
         ST_LIST: begin
            if (sts.out_free && (sts.work_zero || sts.rest_zero)) state_in = ST_IDLE;
         end
         ST_COUNT: begin
            if (sts.work_zero && sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_APPLY_RD: begin
            if (sts.apply_done) begin
               cmd.apply_end = 1'b1;
            end else if (sts.apply_member) begin
               cmd.apply_read = 1'b1;
            end else begin
               cmd.apply_skip = 1'b1;
            end
         end
         ST_APPLY_WR: cmd.apply_write = 1'b1;
         ST_FETCH:    cmd.fetch = 1'b1;
         ST_LIST:     cmd.list_emit = sts.out_free;
         ST_COUNT: begin
            cmd.count_step = !sts.work_zero;
            cmd.count_emit = sts.work_zero && sts.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ----- rtl/sme_datapath.sv -----
module sme_datapath
   import sme_pkg::*;
#(
   parameter int MAX_FILES = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_data,
   input  logic            csr_we,
   input  logic [CNT_W-1:0] csr_wdata,
   input  dp_cmd_type      cmd,
   input  logic            rsp_ready,
   output dp_sts_type      sts,
   output logic            rsp_valid,
   output rsp_payload_type rsp_data
);

   localparam int IDX_W = $clog2(MAX_FILES);

   // Row store, no reset; a row never written reads as zero via its valid bit
   logic [MAX_FILES-1:0] mem [MAX_FILES];
   logic [MAX_FILES-1:0] row_valid_ff;
   logic [MAX_FILES-1:0] rd_ff;
   logic                 rd_ok_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic [MAX_FILES-1:0] rd_eff;

   logic [CNT_W-1:0]     file_count_ff;
   logic [CNT_W-1:0]     n_eff;
   logic [MAX_FILES-1:0] col_mask;

   logic [MAX_FILES-1:0] group_mask_ff, group_mask_in;
   logic [MAX_FILES-1:0] member_mask;
   logic [CNT_W-1:0]     row_ff, row_in;
   logic [IDX_W-1:0]     row_idx;

   logic [FILE_W-1:0]    idx_ff;
   logic                 in_range_ff;
   logic                 is_count_ff;
   logic                 req_in_range;

   logic [MAX_FILES-1:0] work_ff, work_in;
   logic [MAX_FILES-1:0] work_rest;
   logic [MAX_FILES-1:0] low_bit;
   logic [IDX_W-1:0]     low_col;
   logic [MAX_FILES-1:0] own_bit;
   logic [FILE_W-1:0]    count_ff, count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   // Active file count, saturated to the store depth
   assign n_eff = (file_count_ff > CNT_W'(MAX_FILES)) ? CNT_W'(MAX_FILES) : file_count_ff;

   always_comb begin
      for (int i = 0; i < MAX_FILES; i++) begin
         col_mask[i] = CNT_W'(i) < n_eff;
      end
   end

   assign req_in_range = {1'b0, req_data.file_sel} < n_eff;

   // Config register
   always_ff @(posedge clock) begin
      if (reset) begin
         file_count_ff <= FILE_COUNT_RESET;
      end else if (csr_we) begin
         file_count_ff <= csr_wdata;
      end
   end

   // Group walk bookkeeping
   assign member_mask = group_mask_ff & col_mask;
   assign row_idx     = row_ff[IDX_W-1:0];

   always_comb begin
      group_mask_in = group_mask_ff;
      if (cmd.take && req_data.operation == OP_ADD && req_in_range) begin
         group_mask_in[req_data.file_sel[IDX_W-1:0]] = 1'b1;
      end
      if (cmd.apply_end) group_mask_in = '0;
   end

   always_comb begin
      row_in = row_ff;
      if (cmd.take) begin
         row_in = '0;
      end else if (cmd.apply_skip || cmd.apply_write) begin
         row_in = row_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_mask_ff <= '0;
         row_valid_ff  <= '0;
      end else begin
         group_mask_ff <= group_mask_in;
         if (cmd.apply_write) row_valid_ff[row_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   // Memory: one registered read, one write
   assign rd_addr = cmd.apply_read ? row_idx : req_data.file_sel[IDX_W-1:0];
   assign rd_eff  = rd_ok_ff ? rd_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.apply_write) mem[row_idx] <= rd_eff | member_mask;
      rd_ff    <= mem[rd_addr];
      rd_ok_ff <= row_valid_ff[rd_addr];
   end

   // Latched query
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         idx_ff      <= req_data.file_sel;
         in_range_ff <= req_in_range;
         is_count_ff <= req_data.operation == OP_COUNT;
      end
   end

   // Lowest set column of the working row
   assign low_bit   = work_ff & (~work_ff + 1'b1);
   assign work_rest = work_ff & (work_ff - 1'b1);
   assign own_bit   = MAX_FILES'(1) << idx_ff[IDX_W-1:0];

   always_comb begin
      low_col = '0;
      for (int i = 0; i < MAX_FILES; i++) begin
         if (low_bit[i]) low_col = low_col | IDX_W'(i);
      end
   end

   always_comb begin
      work_in  = work_ff;
      count_in = count_ff;
      if (cmd.fetch) begin
         count_in = '0;
         if (!in_range_ff) begin
            work_in = '0;
         end else if (is_count_ff) begin
            work_in = rd_eff & col_mask & ~own_bit;
         end else begin
            work_in = rd_eff & col_mask;
         end
      end else if (cmd.list_emit || cmd.count_step) begin
         work_in = work_rest;
      end
      if (cmd.count_step) count_in = count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      count_ff <= count_in;
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.list_emit) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in                 = '0;
         rsp_data_in.similar_file    = (work_ff == '0) ? '0 : FILE_W'(low_col);
         rsp_data_in.last_of_run     = (work_ff == '0) || (work_rest == '0);
         rsp_data_in.none_found      = work_ff == '0;
      end else if (cmd.count_emit) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in                 = '0;
         rsp_data_in.last_of_run     = 1'b1;
         rsp_data_in.duplicate_count = count_ff;
         rsp_data_in.has_duplicates  = count_ff != '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Status
   assign sts.apply_done   = row_ff >= n_eff;
   assign sts.apply_member = member_mask[row_idx];
   assign sts.is_count     = is_count_ff;
   assign sts.work_zero    = work_ff == '0;
   assign sts.rest_zero    = work_rest == '0;
   assign sts.out_free     = !rsp_valid_ff || rsp_ready;

endmodule

// ----- rtl/similarity_matrix_engine.sv -----
// Similarity matrix engine: a MAX_FILES-square bit matrix of which files are
// similar, cleared at reset (per-row valid bits, no clearing pass). Add
// (operation 0) marks a group member; an add flagged group_last then walks
// rows 0 to n-1, where n is file_count saturated at MAX_FILES, reading each
// member row and then writing it back with the group ORed in. A listing
// fetches the row, then issues one result per set column, lowest first, one
// per cycle while the result side takes them; an empty row gives one
// none_found result. A duplicate count fetches the row, clears one set bit
// per cycle, then issues one result. One item is in work at a time; the
// result register lets a finished result wait while the next item is taken.
// The user writes file_count only while idle; the block does not enforce it.
module similarity_matrix_engine
   import sme_pkg::*;
#(
   parameter int MAX_FILES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_payload_type  req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_payload_type  rsp_data,
   input  logic             csr_we,
   input  logic [CNT_W-1:0] csr_wdata
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   sme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .sts       (sts),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   sme_datapath #(
      .MAX_FILES (MAX_FILES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // A group apply closes the input side once it is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.operation == OP_ADD && req_data.group_last
      |=> !req_ready)
      else $error("input taken during group apply");

   // A query closes the input side once it is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_data.operation == OP_LIST || req_data.operation == OP_COUNT)
      |=> !req_ready)
      else $error("input taken while query in work");

   // An empty listing is a single, closing result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.none_found
      |-> rsp_data.last_of_run && rsp_data.duplicate_count == '0 &&
          rsp_data.similar_file == '0)
      else $error("malformed none-found result");

   // Duplicate flag tracks the count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.has_duplicates == (rsp_data.duplicate_count != '0))
      else $error("has_duplicates disagrees with duplicate_count");

endmodule

// ----- tb/similarity_matrix_engine_tb.sv -----
module similarity_matrix_engine_tb;
   import sme_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // Settle time after a group apply, which walks every active row; leave ample margin
   localparam int SETTLE_CYCLES  = 200;
   localparam int WATCHDOG_LIMIT = 2000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_payload_type  req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_payload_type  rsp_data;
   logic             csr_we = 1'b0;
   logic [CNT_W-1:0] csr_wdata = '0;

   // Shadow copy of the matrix, pending group and file count
   logic [63:0]      sim_rows [64];
   logic [63:0]      pending_group;
   logic [CNT_W-1:0] files_in_use;
   rsp_payload_type  awaited_results [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int failures = 0;
   int items_sent = 0;
   int results_checked = 0;
   int lists_sent = 0;
   int counts_sent = 0;
   int idle_cycles = 0;

   similarity_matrix_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // File count as the block sees it: saturates at 64
   function automatic int unsigned active_files();
      return (files_in_use > 7'd64) ? 64 : int'(files_in_use);
   endfunction

   // Update the shadow matrix for one item and queue the results it causes
   function automatic void similarity_step(input req_payload_type item);
      int unsigned     n;
      logic [63:0]     cols;
      logic [63:0]     row;
      logic [63:0]     group;
      rsp_payload_type res;
      n = active_files();
      cols = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
      case (item.operation)
         OP_ADD: begin
            if (item.file_sel < n) pending_group[item.file_sel] = 1'b1;
            if (item.group_last) begin
               group = pending_group & cols;
               for (int r = 0; r < 64; r++) begin
                  if (group[r]) sim_rows[r] |= group;
               end
               pending_group = '0;
            end
         end
         OP_LIST: begin
            row = (item.file_sel < n) ? (sim_rows[item.file_sel] & cols) : '0;
            if (row == '0) begin
               res = '0;
               res.last_of_run = 1'b1;
               res.none_found = 1'b1;
               awaited_results.push_back(res);
            end else begin
               for (int r = 0; r < 64; r++) begin
                  if (row[r]) begin
                     row[r] = 1'b0;
                     res = '0;
                     res.similar_file = r[FILE_W-1:0];
                     res.last_of_run = (row == '0);
                     awaited_results.push_back(res);
                  end
               end
            end
         end
         OP_COUNT: begin
            res = '0;
            res.last_of_run = 1'b1;
            if (item.file_sel < n) begin
               row = sim_rows[item.file_sel] & cols;
               row[item.file_sel] = 1'b0;
               res.duplicate_count = FILE_W'($countones(row));
            end
            res.has_duplicates = (res.duplicate_count != '0);
            awaited_results.push_back(res);
         end
         default: ;
      endcase
   endfunction

   // Mostly a file below the active count, sometimes anywhere
   function automatic logic [FILE_W-1:0] pick_file();
      int unsigned n;
      n = active_files();
      if (n != 0 && $urandom_range(99) < 80) return FILE_W'($urandom_range(n - 1));
      return FILE_W'($urandom_range(63));
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   // One request transfer; valid stays up if the next item follows at once
   task automatic send_item(input logic [OP_W-1:0] op, input logic [FILE_W-1:0] index,
                            input logic last);
      req_payload_type item;
      item.operation = op;
      item.file_sel = index;
      item.group_last = last;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      similarity_step(item);
      if (op != OP_UNUSED) items_sent++;
      if (op == OP_LIST) lists_sent++;
      if (op == OP_COUNT) counts_sent++;
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
   endtask

   // Register write only once the block is idle, including any group walk
   task automatic write_file_count(input logic [CNT_W-1:0] value);
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      files_in_use = value;
   endtask

   task automatic test_reset_state();
      send_item(OP_LIST, 6'd0, 1'b0);
      send_item(OP_COUNT, 6'd63, 1'b0);
   endtask

   // Three-member clique on both ends of the index range
   task automatic test_group_clique();
      send_item(OP_ADD, 6'd0, 1'b0);
      send_item(OP_ADD, 6'd63, 1'b0);
      send_item(OP_ADD, 6'd5, 1'b1);
      send_item(OP_LIST, 6'd63, 1'b0);
      send_item(OP_COUNT, 6'd5, 1'b1);
      send_item(OP_LIST, 6'd0, 1'b1);
   endtask

   task automatic test_unused_operation();
      send_item(OP_UNUSED, 6'd63, 1'b1);
      send_item(OP_COUNT, 6'd63, 1'b0);
   endtask

   // Lone member: diagonal set, but the count leaves its own file out
   task automatic test_single_member();
      send_item(OP_ADD, 6'd10, 1'b1);
      send_item(OP_COUNT, 6'd10, 1'b0);
      send_item(OP_LIST, 6'd10, 1'b0);
   endtask

   // Index beyond count: not a member, but its last flag still applies
   task automatic test_narrow_count();
      write_file_count(7'd8);
      send_item(OP_ADD, 6'd2, 1'b0);
      send_item(OP_ADD, 6'd9, 1'b1);
      send_item(OP_LIST, 6'd2, 1'b0);
      send_item(OP_LIST, 6'd63, 1'b0);
      send_item(OP_COUNT, 6'd0, 1'b0);
      send_item(OP_ADD, 6'd4, 1'b0);
   endtask

   // Zero count ignores the add but its last flag drops the pending member
   task automatic test_zero_count();
      write_file_count(7'd0);
      send_item(OP_ADD, 6'd1, 1'b1);
      send_item(OP_LIST, 6'd0, 1'b0);
      send_item(OP_COUNT, 6'd0, 1'b0);
      write_file_count(7'd64);
      send_item(OP_ADD, 6'd6, 1'b1);
      send_item(OP_LIST, 6'd6, 1'b0);
   endtask

   // Counts above the matrix size saturate; a count of one hides stale columns
   task automatic test_saturated_count();
      write_file_count(7'd127);
      send_item(OP_LIST, 6'd63, 1'b0);
      write_file_count(7'd65);
      send_item(OP_COUNT, 6'd0, 1'b0);
      write_file_count(7'd1);
      send_item(OP_LIST, 6'd0, 1'b0);
      send_item(OP_COUNT, 6'd0, 1'b0);
   endtask

   // Mostly whole groups followed by queries, plus broken groups and noise
   task automatic run_random_phase(input int item_goal, input int sender_pct,
                                   input int receiver_pct, input bit pause_midway);
      int first;
      int group_size;
      int choice;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      first = items_sent;
      while (items_sent - first < item_goal) begin
         if (pause_midway && items_sent - first >= item_goal / 2) begin
            pause_midway = 1'b0;
            hold_until_drained();
         end
         choice = $urandom_range(99);
         if (choice < 45) begin
            group_size = ($urandom_range(3) == 0) ? $urandom_range(12, 1) : $urandom_range(4, 1);
            for (int m = 1; m <= group_size; m++) begin
               // a few groups end without the last flag and merge into the next
               send_item(OP_ADD, pick_file(), (m == group_size) && (choice > 2));
            end
         end else if (choice < 72) begin
            send_item(OP_LIST, pick_file(), 1'($urandom_range(1)));
         end else if (choice < 95) begin
            send_item(OP_COUNT, pick_file(), 1'($urandom_range(1)));
         end else begin
            send_item(OP_UNUSED, FILE_W'($urandom_range(63)), 1'($urandom_range(1)));
         end
      end
   endtask

   // Result side stalls at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin : result_check
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (awaited_results.size() == 0) begin
            $error("unexpected result: similar_file %0d none_found %0d count %0d",
                   rsp_data.similar_file, rsp_data.none_found, rsp_data.duplicate_count);
            failures++;
         end else begin
            want = awaited_results.pop_front();
            check_field("similar_file", want.similar_file, rsp_data.similar_file);
            check_field("last_of_run", want.last_of_run, rsp_data.last_of_run);
            check_field("none_found", want.none_found, rsp_data.none_found);
            check_field("duplicate_count", want.duplicate_count, rsp_data.duplicate_count);
            check_field("has_duplicates", want.has_duplicates, rsp_data.has_duplicates);
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                  idle_cycles, awaited_results.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      for (int r = 0; r < 64; r++) sim_rows[r] = '0;
      pending_group = '0;
      files_in_use = FILE_COUNT_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_group_clique();
      test_unused_operation();
      test_single_member();
      test_narrow_count();
      test_zero_count();
      test_saturated_count();

      write_file_count(7'd16);
      run_random_phase(85, 17, 52, 1'b1);
      write_file_count(7'd64);
      run_random_phase(85, 52, 17, 1'b0);
      write_file_count(CNT_W'($urandom_range(64, 1)));
      run_random_phase(85, 0, 0, 1'b0);

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("tb: %0d items (%0d listings, %0d counts), %0d results checked",
               items_sent, lists_sent, counts_sent, results_checked);
      $display("tb: file counts 0, 1, 8, 16, 64, 65, 127 and one random, mixed stalls");
      if (failures == 0 && awaited_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/sme_pkg.sv
rtl/sme_ctrl.sv
rtl/sme_datapath.sv
rtl/similarity_matrix_engine.sv
tb/similarity_matrix_engine_tb.sv
